// ===== sv/rgbhsv_pkg.sv =====
// rgbhsv_pkg: shared widths, types and constants of the rgb to hsv light color block
// used by rgbhsv_front and rgb_to_hsv_light_color; no dependencies
`default_nettype none

package rgbhsv_pkg;

    localparam int TAG_W        = 6;
    localparam int CH_W         = 8;
    localparam int HUE_W        = 16;
    localparam int NUM_W        = 11;   // holds 6 * 254
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = 4;    // must divide HUE_W and CH_W

    localparam logic [CH_W-1:0] CH_LIMIT = 8'd254;

    typedef logic [CH_W-1:0]          t_ch;
    typedef logic [NUM_W-1:0]         t_num;
    typedef logic [NUM_W+HUE_W-1:0]   t_hue_dvd;
    typedef logic [2*CH_W-1:0]        t_sat_dvd;

    // which channel holds the maximum, red wins ties over green, green over blue
    typedef enum logic [1:0] {
        MAXCH_RED,
        MAXCH_GREEN,
        MAXCH_BLUE
    } t_maxch;

    // fields that ride alongside the dividers
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             on;
        logic [CH_W-1:0]  bri;
    } t_side;

endpackage

`default_nettype wire

// ===== sv/rgb_to_hsv_light_color.sv =====
// rgb_to_hsv_light_color: rgb to hsv conversion for light control, 0..254 channel and saturation scales, 16-bit hue
// a request passes three front register stages, then DIV_STAGES divider stages
// throughput one request per cycle while i_stall is low; every stage advances when it is empty or drained
// synchronous active-low reset clears the stage valid bits only
// uses rgbhsv_pkg, rgbhsv_front and rgbhsv_div
`default_nettype none

module rgb_to_hsv_light_color #(
    parameter int DIV_STAGES = rgbhsv_pkg::DIV_STAGES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input request channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rgbhsv_pkg::TAG_W-1:0] i_light_id,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0]  i_blue,
    // result request channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [rgbhsv_pkg::TAG_W-1:0]      o_light_tag,
    output logic                              o_light_on,
    output logic [rgbhsv_pkg::HUE_W-1:0]      o_hue,
    output logic [rgbhsv_pkg::CH_W-1:0]       o_saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]       o_brightness
);

    localparam int FRONT = rgbhsv_pkg::FRONT_STAGES;
    localparam int NSTG  = FRONT + DIV_STAGES;

    // one valid bit per register stage; the last stage is the output register
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] c_en;

    // a stage loads when it holds nothing or its content moves on this cycle,
    // so bubbles squeeze out and a waiting result does not block new requests while an empty stage remains
    always_comb begin
        c_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            c_en[k] = !r_vld[k] || c_en[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < NSTG; k++) begin
            if (c_en[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !c_en[0];
    assign o_valid = r_vld[NSTG-1];

    // front end: clamp, grey fix, max/min, numerator and divider operands
    rgbhsv_pkg::t_side    w_side;
    rgbhsv_pkg::t_hue_dvd w_hue_dvd;
    rgbhsv_pkg::t_num     w_hue_dvs;
    rgbhsv_pkg::t_sat_dvd w_sat_dvd;
    rgbhsv_pkg::t_ch      w_sat_dvs;

    rgbhsv_front u_front (
        .i_clk      (i_clk),
        .i_en       (c_en[FRONT-1:0]),
        .i_light_id (i_light_id),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .o_side     (w_side),
        .o_hue_dvd  (w_hue_dvd),
        .o_hue_dvs  (w_hue_dvs),
        .o_sat_dvd  (w_sat_dvd),
        .o_sat_dvs  (w_sat_dvs)
    );

    // hue = num * 65535 / (6 d), quotient spread over the divider stages
    rgbhsv_div #(
        .DVS_W  (rgbhsv_pkg::NUM_W),
        .QUO_W  (rgbhsv_pkg::HUE_W),
        .STAGES (DIV_STAGES)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (c_en[NSTG-1:FRONT]),
        .i_dvd (w_hue_dvd),
        .i_dvs (w_hue_dvs),
        .o_quo (o_hue)
    );

    // saturation = d * 254 / mx, same stage count so both results line up
    rgbhsv_div #(
        .DVS_W  (rgbhsv_pkg::CH_W),
        .QUO_W  (rgbhsv_pkg::CH_W),
        .STAGES (DIV_STAGES)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (c_en[NSTG-1:FRONT]),
        .i_dvd (w_sat_dvd),
        .i_dvs (w_sat_dvs),
        .o_quo (o_saturation)
    );

    // tag, on flag and brightness travel beside the dividers
    rgbhsv_pkg::t_side r_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (c_en[FRONT+k]) begin
                r_side[k] <= (k == 0) ? w_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_light_tag  = r_side[DIV_STAGES-1].tag;
    assign o_light_on   = r_side[DIV_STAGES-1].on;
    assign o_brightness = r_side[DIV_STAGES-1].bri;

endmodule

`default_nettype wire

// ===== sv/rgbhsv_div.sv =====
// rgbhsv_div: pipelined restoring divider, QUO_W / STAGES quotient bits per register stage
// quotient must fit in QUO_W bits; no package dependencies
`default_nettype none

module rgbhsv_div #(
    parameter int DVS_W  = 8,
    parameter int QUO_W  = 8,
    parameter int STAGES = 4
) (
    input  wire logic                   i_clk,
    input  wire logic [STAGES-1:0]      i_en,
    input  wire logic [DVS_W+QUO_W-1:0] i_dvd,
    input  wire logic [DVS_W-1:0]       i_dvs,
    output logic      [QUO_W-1:0]       o_quo
);

    localparam int BPS   = QUO_W / STAGES;
    localparam int DVD_W = DVS_W + QUO_W;

    // partial remainder, shifting dividend/quotient word and divisor per stage
    logic [DVS_W-1:0] r_rem [STAGES-1];
    logic [DVS_W-1:0] r_dvs [STAGES-1];
    logic [QUO_W-1:0] r_lq  [STAGES];

    for (genvar gs = 0; gs < STAGES; gs++) begin : g_stage
        logic [DVS_W-1:0] w_rem;
        logic [DVS_W-1:0] w_dvs;
        logic [QUO_W-1:0] w_lq;
        logic [DVS_W-1:0] n_rem;
        logic [QUO_W-1:0] n_lq;
        logic [DVS_W:0]   c_t;
        logic             c_ge;

        if (gs == 0) begin : g_first
            assign w_rem = i_dvd[DVD_W-1:QUO_W];
            assign w_lq  = i_dvd[QUO_W-1:0];
            assign w_dvs = i_dvs;
        end else begin : g_next
            assign w_rem = r_rem[gs-1];
            assign w_lq  = r_lq[gs-1];
            assign w_dvs = r_dvs[gs-1];
        end

        always_comb begin
            n_rem = w_rem;
            n_lq  = w_lq;
            c_t   = '0;
            c_ge  = 1'b0;
            for (int k = 0; k < BPS; k++) begin
                c_t  = {n_rem, n_lq[QUO_W-1]};
                c_ge = (c_t >= {1'b0, w_dvs});
                if (c_ge) begin
                    c_t = c_t - {1'b0, w_dvs};
                end
                n_rem = c_t[DVS_W-1:0];
                n_lq  = {n_lq[QUO_W-2:0], c_ge};
            end
        end

        if (gs < STAGES - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en[gs]) begin
                    r_rem[gs] <= n_rem;
                    r_dvs[gs] <= w_dvs;
                    r_lq[gs]  <= n_lq;
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en[gs]) begin
                    r_lq[gs] <= n_lq;
                end
            end
        end
    end

    assign o_quo = r_lq[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/rgbhsv_front.sv =====
// rgbhsv_front: clamp, grey fix, max/min, hue numerator and divider operands
// three register stages; uses rgbhsv_pkg
`default_nettype none

module rgbhsv_front (
    input  wire logic                         i_clk,
    input  wire logic [2:0]                   i_en,
    input  wire logic [rgbhsv_pkg::TAG_W-1:0] i_light_id,
    input  wire rgbhsv_pkg::t_ch              i_red,
    input  wire rgbhsv_pkg::t_ch              i_green,
    input  wire rgbhsv_pkg::t_ch              i_blue,
    output rgbhsv_pkg::t_side                 o_side,
    output rgbhsv_pkg::t_hue_dvd              o_hue_dvd,
    output rgbhsv_pkg::t_num                  o_hue_dvs,
    output rgbhsv_pkg::t_sat_dvd              o_sat_dvd,
    output rgbhsv_pkg::t_ch                   o_sat_dvs
);

    // stage 1: clamp, grey fix, max, min
    rgbhsv_pkg::t_ch    c_r, c_g, c_b, c_r2;
    rgbhsv_pkg::t_ch    n1_mx, n1_mn;
    rgbhsv_pkg::t_maxch n1_sel;
    rgbhsv_pkg::t_side  n1_side;

    rgbhsv_pkg::t_ch    r1_r, r1_g, r1_b, r1_mx, r1_mn;
    rgbhsv_pkg::t_maxch r1_sel;
    rgbhsv_pkg::t_side  r1_side;

    always_comb begin
        c_r = (i_red   > rgbhsv_pkg::CH_LIMIT) ? rgbhsv_pkg::CH_LIMIT : i_red;
        c_g = (i_green > rgbhsv_pkg::CH_LIMIT) ? rgbhsv_pkg::CH_LIMIT : i_green;
        c_b = (i_blue  > rgbhsv_pkg::CH_LIMIT) ? rgbhsv_pkg::CH_LIMIT : i_blue;
        c_r2 = c_r;
        if (c_r == c_g && c_g == c_b && c_r != '0) begin
            c_r2 = c_r - 1'b1;
        end
        if (c_r2 >= c_g && c_r2 >= c_b) begin
            n1_sel = rgbhsv_pkg::MAXCH_RED;
            n1_mx  = c_r2;
        end else if (c_g >= c_b) begin
            n1_sel = rgbhsv_pkg::MAXCH_GREEN;
            n1_mx  = c_g;
        end else begin
            n1_sel = rgbhsv_pkg::MAXCH_BLUE;
            n1_mx  = c_b;
        end
        n1_mn = c_r2;
        if (c_g < n1_mn) begin
            n1_mn = c_g;
        end
        if (c_b < n1_mn) begin
            n1_mn = c_b;
        end
        n1_side.tag = i_light_id;
        n1_side.on  = (i_red != '0) || (i_green != '0) || (i_blue != '0);
        n1_side.bri = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_r    <= c_r2;
            r1_g    <= c_g;
            r1_b    <= c_b;
            r1_mx   <= n1_mx;
            r1_mn   <= n1_mn;
            r1_sel  <= n1_sel;
            r1_side <= n1_side;
        end
    end

    // stage 2: difference, six times difference, hue numerator, brightness
    rgbhsv_pkg::t_ch   n2_d;
    rgbhsv_pkg::t_num  n2_d6, n2_num;
    rgbhsv_pkg::t_side n2_side;

    rgbhsv_pkg::t_ch   r2_d, r2_mx;
    rgbhsv_pkg::t_num  r2_d6, r2_num;
    rgbhsv_pkg::t_side r2_side;

    always_comb begin
        n2_d  = r1_mx - r1_mn;
        n2_d6 = rgbhsv_pkg::t_num'({n2_d, 2'b00}) + rgbhsv_pkg::t_num'({n2_d, 1'b0});
        case (r1_sel)
            rgbhsv_pkg::MAXCH_RED: begin
                if (r1_g >= r1_b) begin
                    n2_num = rgbhsv_pkg::t_num'(r1_g - r1_b);
                end else begin
                    n2_num = n2_d6 - rgbhsv_pkg::t_num'(r1_b - r1_g);
                end
            end
            rgbhsv_pkg::MAXCH_GREEN: begin
                n2_num = rgbhsv_pkg::t_num'({n2_d, 1'b0}) + rgbhsv_pkg::t_num'(r1_b)
                         - rgbhsv_pkg::t_num'(r1_r);
            end
            rgbhsv_pkg::MAXCH_BLUE: begin
                n2_num = rgbhsv_pkg::t_num'({n2_d, 2'b00}) + rgbhsv_pkg::t_num'(r1_r)
                         - rgbhsv_pkg::t_num'(r1_g);
            end
            default: begin
                n2_num = '0;
            end
        endcase
        n2_side = r1_side;
        // floor(mx * 254 / 255) is mx - 1 for mx in 1..254
        n2_side.bri = (r1_mx == '0) ? '0 : r1_mx - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_d    <= n2_d;
            r2_mx   <= r1_mx;
            r2_d6   <= n2_d6;
            r2_num  <= n2_num;
            r2_side <= n2_side;
        end
    end

    // stage 3: divider operands, zero divisors become all ones over a zero dividend
    rgbhsv_pkg::t_hue_dvd n3_hue_dvd;
    rgbhsv_pkg::t_num     n3_hue_dvs;
    rgbhsv_pkg::t_sat_dvd n3_sat_dvd;
    rgbhsv_pkg::t_ch      n3_sat_dvs;

    rgbhsv_pkg::t_hue_dvd r3_hue_dvd;
    rgbhsv_pkg::t_num     r3_hue_dvs;
    rgbhsv_pkg::t_sat_dvd r3_sat_dvd;
    rgbhsv_pkg::t_ch      r3_sat_dvs;
    rgbhsv_pkg::t_side    r3_side;

    always_comb begin
        if (r2_d == '0) begin
            n3_hue_dvd = '0;
            n3_hue_dvs = '1;
        end else begin
            // num * 65535
            n3_hue_dvd = {r2_num, {rgbhsv_pkg::HUE_W{1'b0}}}
                         - rgbhsv_pkg::t_hue_dvd'(r2_num);
            n3_hue_dvs = r2_d6;
        end
        // d * 254
        n3_sat_dvd = {r2_d, {rgbhsv_pkg::CH_W{1'b0}}} - rgbhsv_pkg::t_sat_dvd'({r2_d, 1'b0});
        n3_sat_dvs = (r2_mx == '0) ? '1 : r2_mx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_hue_dvd <= n3_hue_dvd;
            r3_hue_dvs <= n3_hue_dvs;
            r3_sat_dvd <= n3_sat_dvd;
            r3_sat_dvs <= n3_sat_dvs;
            r3_side    <= r2_side;
        end
    end

    assign o_side    = r3_side;
    assign o_hue_dvd = r3_hue_dvd;
    assign o_hue_dvs = r3_hue_dvs;
    assign o_sat_dvd = r3_sat_dvd;
    assign o_sat_dvs = r3_sat_dvs;

endmodule

`default_nettype wire
